// ===== rtl/core/tgu_pkg.sv =====
// Shared constants, weight table and control types of the tricubic grid upsampler.
`default_nettype none
package tgu_pkg;

	localparam int COARSE_X = 8;
	localparam int COARSE_Y = 8;
	localparam int COARSE_Z = 8;
	localparam int RATIO    = 2;

	localparam int NCOARSE = COARSE_X * COARSE_Y * COARSE_Z;
	localparam int FINE_X  = COARSE_X * RATIO;
	localparam int FINE_Y  = COARSE_Y * RATIO;
	localparam int FINE_Z  = COARSE_Z * RATIO;

	localparam int ADDR_W = $clog2(NCOARSE);
	localparam int CNT_W  = $clog2(NCOARSE + 1);
	localparam int CX_W   = $clog2(COARSE_X);
	localparam int CY_W   = $clog2(COARSE_Y);
	localparam int CZ_W   = $clog2(COARSE_Z);
	localparam int PH_W   = (RATIO > 1) ? $clog2(RATIO) : 1;
	localparam int W_W    = 18;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_COEF = 2'd1;
	localparam logic [1:0] RES_READ = 2'd2;

	typedef logic signed [W_W-1:0] wtab_t [RATIO*4];

	// Lagrange weight for phase ph and tap t in Q.16, rounded half away from zero.
	function automatic wtab_t build_wtab();
		longint r;
		longint f;
		longint n;
		longint d;
		longint unsigned m;
		longint unsigned q;
		longint unsigned num;
		longint unsigned den;
		longint unsigned rem;
		wtab_t tab;
		r = RATIO;
		d = 6 * r * r * r;
		for (int ph = 0; ph < RATIO; ph++) begin
			for (int t = 0; t < 4; t++) begin
				f = ph;
				if (t == 0) n = -f * (r - f) * (2 * r - f);
				else if (t == 1) n = 3 * (r + f) * (r - f) * (2 * r - f);
				else if (t == 2) n = 3 * (r + f) * f * (2 * r - f);
				else n = -(r + f) * f * (r - f);
				m = (n < 0) ? longint'(-n) : longint'(n);
				num = 2 * m * 65536 + longint'(d);
				den = 2 * longint'(d);
				q = 0;
				rem = 0;
				// Shift-and-subtract long division of the rounded numerator.
				for (int b = 63; b >= 0; b--) begin
					rem = (rem << 1) | ((num >> b) & 64'd1);
					if (rem >= den) begin
						rem = rem - den;
						q = q | (64'd1 << b);
					end
				end
				tab[ph*4 + t] = (n < 0) ? -W_W'(q) : W_W'(q);
			end
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_wtab();

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       walk_init;
		logic       walk_next;
		logic       rdiv_init;
		logic       rdiv_step;
		logic       pt_start;
		logic       tap_issue;
		logic       pt_finish;
		logic       facc;
		logic       mul1;
		logic       mul2;
		logic       qdiv_step;
		logic       coef_store;
		logic       rmul;
		logic       out_load;
		logic [1:0] res_sel;
		logic [1:0] res_status;
	} tgu_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       full;
		logic       norm;
		logic       out_of_range;
		logic       div_done;
		logic       tap_last;
		logic       pipe_busy;
		logic       walk_last;
		logic       qdiv_last;
	} tgu_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/tgu_if.sv =====
// Stream interfaces for the upsampler input and result channels.
`default_nettype none
interface tgu_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  command;
	logic signed [31:0] sample;
	logic        [7:0]  fine_x;
	logic        [7:0]  fine_y;
	logic        [7:0]  fine_z;
	modport source (output valid, command, sample, fine_x, fine_y, fine_z, input ready);
	modport sink (input valid, command, sample, fine_x, fine_y, fine_z, output ready);
endinterface

interface tgu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic        [1:0]  status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tgu_ctrl.sv =====
// Controller state machine that sequences loads, the finish sweep and reads.
`default_nettype none
module tgu_ctrl import tgu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire tgu_stat_t stat,
	output tgu_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_RDIV   = 4'd3;
	localparam logic [3:0] S_PT     = 4'd4;
	localparam logic [3:0] S_TAPS   = 4'd5;
	localparam logic [3:0] S_DRAIN  = 4'd6;
	localparam logic [3:0] S_PTDONE = 4'd7;
	localparam logic [3:0] S_FACC   = 4'd8;
	localparam logic [3:0] S_MUL1   = 4'd9;
	localparam logic [3:0] S_MUL2   = 4'd10;
	localparam logic [3:0] S_QDIV   = 4'd11;
	localparam logic [3:0] S_COEF   = 4'd12;
	localparam logic [3:0] S_RMUL   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] sel_q;
	logic [1:0] sel_d;
	logic [1:0] rst_q;
	logic [1:0] rst_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		sel_d   = sel_q;
		rst_d   = rst_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				sel_d   = RES_ZERO;
				rst_d   = ST_OK;
				state_d = S_DONE;
				case (stat.command)
					CMD_LOAD: state_d = S_LOAD;
					CMD_FINISH: begin
						if (!stat.full) begin
							rst_d = ST_NOT_READY;
						end else begin
							cmd.walk_init = 1'b1;
							state_d       = S_PT;
						end
					end
					CMD_READ: begin
						if (!stat.norm) begin
							rst_d = ST_NOT_READY;
						end else if (stat.out_of_range) begin
							rst_d = ST_RANGE;
						end else begin
							cmd.rdiv_init = 1'b1;
							state_d       = S_RDIV;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DONE;
			end
			S_RDIV: begin
				cmd.rdiv_step = 1'b1;
				if (stat.div_done) state_d = S_PT;
			end
			S_PT: begin
				cmd.pt_start = 1'b1;
				state_d      = S_TAPS;
			end
			S_TAPS: begin
				cmd.tap_issue = 1'b1;
				if (stat.tap_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) state_d = S_PTDONE;
			end
			S_PTDONE: begin
				cmd.pt_finish = 1'b1;
				state_d = (stat.command == CMD_FINISH) ? S_FACC : S_RMUL;
			end
			S_FACC: begin
				cmd.facc = 1'b1;
				if (stat.walk_last) begin
					state_d = S_MUL1;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = S_PT;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_QDIV;
			end
			S_QDIV: begin
				cmd.qdiv_step = 1'b1;
				if (stat.qdiv_last) state_d = S_COEF;
			end
			S_COEF: begin
				cmd.coef_store = 1'b1;
				sel_d          = RES_COEF;
				rst_d          = ST_OK;
				state_d        = S_DONE;
			end
			S_RMUL: begin
				cmd.rmul = 1'b1;
				sel_d    = RES_READ;
				rst_d    = ST_OK;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.res_sel    = sel_q;
		cmd.res_status = rst_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= RES_ZERO;
			rst_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			rst_q   <= rst_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tgu_datapath.sv =====
// Datapath: coarse memory, interpolation MAC pipeline, sums, divider and result register.
`default_nettype none
module tgu_datapath import tgu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tgu_cmd_t           cmd,
	output tgu_stat_t               stat,
	input  wire logic        [1:0]  in_command,
	input  wire logic signed [31:0] in_sample,
	input  wire logic        [7:0]  in_fine_x,
	input  wire logic        [7:0]  in_fine_y,
	input  wire logic        [7:0]  in_fine_z,
	input  wire logic               cfg_we,
	input  wire logic        [23:0] cfg_wdata,
	output logic signed      [31:0] value,
	output logic             [1:0]  status
);

	// Periodic neighbor: (c + t + n - 1) mod n for c < n and t < 4.
	function automatic logic [4:0] wrap_idx(input logic [4:0] c, input logic [1:0] t,
			input logic [4:0] n);
		logic [5:0] v;
		v = 6'(c) + 6'(t) + 6'(n) - 6'd1;
		if (v >= 6'(n)) v = v - 6'(n);
		if (v >= 6'(n)) v = v - 6'(n);
		return v[4:0];
	endfunction

	logic signed [31:0] mem [NCOARSE];

	logic        [1:0]  cmd_q;
	logic signed [31:0] smp_q;
	logic        [7:0]  fx_q, fy_q, fz_q;
	logic        [23:0] vr_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [47:0] csum_q;
	logic signed [31:0] coef_q;
	logic               norm_q;

	logic [CX_W-1:0] cx_q;
	logic [CY_W-1:0] cy_q;
	logic [CZ_W-1:0] cz_q;
	logic [PH_W-1:0] px_q, py_q, pz_q;
	logic [7:0]      rx_q, ry_q, rz_q;
	logic [5:0]      tap_q;

	logic signed [35:0] wxy_s1;
	logic signed [W_W-1:0] wz_s1;
	logic signed [31:0] rd_s1;
	logic signed [53:0] w3_s2;
	logic signed [31:0] smp_s2;
	logic signed [21:0] pw_s3;
	logic signed [31:0] smp_s3;
	logic signed [53:0] prod_s4;
	logic               v_s1, v_s2, v_s3, v_s4;

	logic signed [63:0] acc_q;
	logic signed [63:0] fine_q;
	logic signed [63:0] fsum_q;
	logic [47:0]        lo_q;
	logic [71:0]        dvd_q;
	logic [63:0]        rem_q;
	logic [63:0]        fm_q;
	logic [32:0]        quo_q;
	logic               neg_q;
	logic [6:0]         bit_q;
	logic [64:0]        rprod_q;
	logic               rneg_q;
	logic signed [31:0] value_q;
	logic [1:0]         status_q;

	logic [4:0]  ix, iy, iz;
	logic [ADDR_W-1:0] addr;
	logic signed [W_W-1:0] wx, wy, wz;
	logic [47:0] cm;
	logic [64:0] rem2;
	logic        ge;
	logic [33:0] q2;
	logic [63:0] fabs;
	logic [32:0] fm33;
	logic [31:0] cabs;
	logic [49:0] rm;
	logic signed [31:0] rd_val;
	logic signed [63:0] w3_rnd;
	logic signed [63:0] acc_rnd;
	logic signed [63:0] w3_ext;
	logic [ADDR_W-1:0] wr_addr;

	// Tap counter bits: x tap high, z tap low.
	always_comb begin
		ix   = wrap_idx(5'(cx_q), tap_q[5:4], 5'(COARSE_X));
		iy   = wrap_idx(5'(cy_q), tap_q[3:2], 5'(COARSE_Y));
		iz   = wrap_idx(5'(cz_q), tap_q[1:0], 5'(COARSE_Z));
		addr = ADDR_W'((int'(ix) * COARSE_Y + int'(iy)) * COARSE_Z + int'(iz));
		wx   = WTAB[{px_q, tap_q[5:4]}];
		wy   = WTAB[{py_q, tap_q[3:2]}];
		wz   = WTAB[{pz_q, tap_q[1:0]}];
	end

	assign wr_addr = (count_q == CNT_W'(NCOARSE)) ? '0 : count_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) mem[wr_addr] <= smp_q;
		rd_s1 <= mem[addr];
	end

	// Rounding right shifts, half away from zero.
	assign w3_ext  = 64'(w3_s2);
	assign w3_rnd  = (w3_ext + (w3_s2[53] ? 64'sh7FFF_FFFF : 64'sh8000_0000)) >>> 32;
	assign acc_rnd = (acc_q + (acc_q[63] ? 64'sh7FFF : 64'sh8000)) >>> 16;

	always_ff @(posedge clk) begin
		wxy_s1  <= wx * wy;
		wz_s1   <= wz;
		w3_s2   <= wxy_s1 * wz_s1;
		smp_s2  <= rd_s1;
		pw_s3   <= 22'(w3_rnd);
		smp_s3  <= smp_s2;
		prod_s4 <= pw_s3 * smp_s3;
	end

	assign cm   = csum_q[47] ? 48'(-csum_q) : 48'(csum_q);
	assign rem2 = {rem_q, dvd_q[71]};
	assign ge   = rem2 >= {1'b0, fm_q};
	assign q2   = {quo_q, ge};
	assign fabs = fine_q[63] ? 64'(-fine_q) : 64'(fine_q);
	assign fm33 = (fabs > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : fabs[32:0];
	assign cabs = coef_q[31] ? 32'(-coef_q) : 32'(coef_q);
	assign rm   = 50'((rprod_q + 65'h8000) >> 16);

	always_comb begin
		if (!rneg_q) rd_val = (rm > 50'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(rm);
		else rd_val = (rm > 50'h8000_0000) ? 32'sh8000_0000 : -32'(rm);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_command;
			smp_q <= in_sample;
			fx_q  <= in_fine_x;
			fy_q  <= in_fine_y;
			fz_q  <= in_fine_z;
		end
		if (cmd.rdiv_init) begin
			rx_q <= fx_q;
			ry_q <= fy_q;
			rz_q <= fz_q;
		end else if (cmd.rdiv_step) begin
			if (rx_q >= 8'(RATIO)) rx_q <= rx_q - 8'(RATIO);
			if (ry_q >= 8'(RATIO)) ry_q <= ry_q - 8'(RATIO);
			if (rz_q >= 8'(RATIO)) rz_q <= rz_q - 8'(RATIO);
		end
		if (cmd.pt_start) acc_q <= '0;
		else if (v_s4) acc_q <= acc_q + 64'(prod_s4);
		if (cmd.pt_finish) fine_q <= acc_rnd;
		if (cmd.walk_init) fsum_q <= '0;
		else if (cmd.facc) fsum_q <= fsum_q + fine_q;
		if (cmd.mul1) lo_q <= cm[23:0] * vr_q;
		if (cmd.mul2) begin
			dvd_q <= {48'(cm[47:24]) * 48'(vr_q), 24'd0} + 72'(lo_q);
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= 7'd71;
			fm_q  <= fsum_q[63] ? 64'(-fsum_q) : 64'(fsum_q);
			neg_q <= csum_q[47] ^ fsum_q[63];
		end else if (cmd.qdiv_step) begin
			dvd_q <= {dvd_q[70:0], 1'b0};
			rem_q <= ge ? 64'(rem2 - {1'b0, fm_q}) : rem2[63:0];
			quo_q <= (q2 > 34'hFFFF_FFFF) ? 33'h1_0000_0000 : q2[32:0];
			bit_q <= bit_q - 7'd1;
		end
		if (cmd.rmul) begin
			rprod_q <= fm33 * cabs;
			rneg_q  <= fine_q[63] ^ coef_q[31];
		end
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_COEF: value_q <= coef_q;
				RES_READ: value_q <= rd_val;
				default:  value_q <= '0;
			endcase
			status_q <= cmd.res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_q    <= 24'h08_0000;
			count_q <= '0;
			csum_q  <= '0;
			coef_q  <= '0;
			norm_q  <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			tap_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (cfg_we) vr_q <= cfg_wdata;
			if (cmd.load) begin
				norm_q <= 1'b0;
				if (count_q == CNT_W'(NCOARSE)) begin
					count_q <= CNT_W'(1);
					csum_q  <= 48'(smp_q);
				end else begin
					count_q <= count_q + CNT_W'(1);
					csum_q  <= csum_q + 48'(smp_q);
				end
			end
			if (cmd.coef_store) begin
				norm_q <= 1'b1;
				if (fm_q == '0) coef_q <= '0;
				else if (!neg_q) coef_q <= (quo_q > 33'h7FFF_FFFF) ? 32'sh7FFF_FFFF
					: 32'(quo_q);
				else coef_q <= (quo_q > 33'h8000_0000) ? 32'sh8000_0000 : -32'(quo_q);
			end
			if (cmd.walk_init || cmd.rdiv_init) begin
				cx_q <= '0;
				cy_q <= '0;
				cz_q <= '0;
				px_q <= '0;
				py_q <= '0;
				pz_q <= '0;
			end else if (cmd.rdiv_step) begin
				// The remainder settles into the phase once it drops below the ratio.
				if (rx_q >= 8'(RATIO)) cx_q <= cx_q + CX_W'(1);
				if (ry_q >= 8'(RATIO)) cy_q <= cy_q + CY_W'(1);
				if (rz_q >= 8'(RATIO)) cz_q <= cz_q + CZ_W'(1);
				px_q <= PH_W'(rx_q);
				py_q <= PH_W'(ry_q);
				pz_q <= PH_W'(rz_q);
			end else if (cmd.walk_next) begin
				if (pz_q != PH_W'(RATIO - 1)) begin
					pz_q <= pz_q + PH_W'(1);
				end else begin
					pz_q <= '0;
					if (cz_q != CZ_W'(COARSE_Z - 1)) begin
						cz_q <= cz_q + CZ_W'(1);
					end else begin
						cz_q <= '0;
						if (py_q != PH_W'(RATIO - 1)) begin
							py_q <= py_q + PH_W'(1);
						end else begin
							py_q <= '0;
							if (cy_q != CY_W'(COARSE_Y - 1)) begin
								cy_q <= cy_q + CY_W'(1);
							end else begin
								cy_q <= '0;
								if (px_q != PH_W'(RATIO - 1)) begin
									px_q <= px_q + PH_W'(1);
								end else begin
									px_q <= '0;
									cx_q <= cx_q + CX_W'(1);
								end
							end
						end
					end
				end
			end
			if (cmd.pt_start) tap_q <= '0;
			else if (cmd.tap_issue) tap_q <= tap_q + 6'd1;
			v_s1 <= cmd.tap_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		stat.command      = cmd_q;
		stat.full         = (count_q == CNT_W'(NCOARSE));
		stat.norm         = norm_q;
		stat.out_of_range = (fx_q >= 8'(FINE_X)) || (fy_q >= 8'(FINE_Y))
			|| (fz_q >= 8'(FINE_Z));
		stat.div_done     = (rx_q < 8'(RATIO)) && (ry_q < 8'(RATIO)) && (rz_q < 8'(RATIO));
		stat.tap_last     = (tap_q == 6'd63);
		stat.pipe_busy    = v_s1 | v_s2 | v_s3 | v_s4;
		stat.walk_last    = (cx_q == CX_W'(COARSE_X - 1)) && (cy_q == CY_W'(COARSE_Y - 1))
			&& (cz_q == CZ_W'(COARSE_Z - 1)) && (px_q == PH_W'(RATIO - 1))
			&& (py_q == PH_W'(RATIO - 1)) && (pz_q == PH_W'(RATIO - 1));
		stat.qdiv_last    = (bit_q == 7'd0);
	end

	assign value  = value_q;
	assign status = status_q;

endmodule
`default_nettype wire

// ===== rtl/core/tricubic_grid_upsampler_top.sv =====
// Top level of the tricubic grid upsampler: controller, datapath and channel ports.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | command, sample, fine_x, fine_y, fine_z
//  out_ch  | out | valid / ready    | value, status
//  cfg     | in  | cfg_we           | cfg_wdata (volume_ratio)
//
// One transaction is worked on at a time. A load writes its sample; a rejected command
// goes from dispatch straight to the result. A read is dispatched, splits the coordinates,
// works the point (64 taps from the single coarse memory port, one per cycle, plus drain)
// and is scaled. A finish works each of the 4096 fine points after dispatch, then forms
// the two partial products and runs the 72-step divider. arst_n clears all control state.
// A waiting result sits in the output register while the next transaction is taken.
`default_nettype none
module tricubic_grid_upsampler_top import tgu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tgu_in_if.sink     in_ch,
	tgu_out_if.source  out_ch,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata
);

	tgu_cmd_t  cmd;
	tgu_stat_t stat;

	tgu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tgu_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (in_ch.command),
		.in_sample  (in_ch.sample),
		.in_fine_x  (in_ch.fine_x),
		.in_fine_y  (in_ch.fine_y),
		.in_fine_z  (in_ch.fine_z),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.value      (out_ch.value),
		.status     (out_ch.status)
	);

`ifndef SYNTHESIS
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !stat.pipe_busy)
		else $error("MAC pipeline busy while idle");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input taken while a transaction is in progress");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.pipe_busy)
		else $error("result loaded before the MAC pipeline drained");
`endif

endmodule
`default_nettype wire

// ===== test/tgu_checker.sv =====
// Checker for the tricubic grid upsampler: predicts each result and compares it.
`default_nettype none
module tgu_checker import tgu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tgu_in_if                in_ch,
	tgu_out_if               out_ch,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] value;
		logic        [1:0]  status;
	} upsample_result_t;

	upsample_result_t expected_results[$];

	logic signed [31:0] grid[NCOARSE];
	longint             fine_cache[FINE_X*FINE_Y*FINE_Z];
	longint             lagrange_w[RATIO][4];
	int                 samples_loaded;
	longint             grid_sum;
	logic signed [31:0] coef;
	bit                 normalized;
	logic        [23:0] vol_ratio;

	initial begin
		longint r;
		longint f;
		longint n;
		longint d;
		longint q;
		fail_count = 0;
		samples_loaded = 0;
		grid_sum = 0;
		coef = 0;
		normalized = 0;
		vol_ratio = 24'h08_0000;
		r = RATIO;
		d = 6 * r * r * r;
		for (int ph = 0; ph < RATIO; ph++) begin
			for (int t = 0; t < 4; t++) begin
				f = ph;
				case (t)
					0: n = -f * (r - f) * (2 * r - f);
					1: n = 3 * (r + f) * (r - f) * (2 * r - f);
					2: n = 3 * (r + f) * f * (2 * r - f);
					default: n = -(r + f) * f * (r - f);
				endcase
				q = (2 * (n < 0 ? -n : n) * 65536 + d) / (2 * d);
				lagrange_w[ph][t] = (n < 0) ? -q : q;
			end
		end
	end

	assign pending = expected_results.size();

	// Rounds half away from zero.
	function automatic longint round_shift(longint v, int sh);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) << (sh - 1))) >>> sh;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint interpolate(int fx, int fy, int fz);
		longint acc;
		longint pw;
		int     ix;
		int     iy;
		int     iz;
		acc = 0;
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 4; b++) begin
				for (int c = 0; c < 4; c++) begin
					pw = round_shift(lagrange_w[fx % RATIO][a] * lagrange_w[fy % RATIO][b]
						* lagrange_w[fz % RATIO][c], 32);
					ix = (fx / RATIO + a + COARSE_X - 1) % COARSE_X;
					iy = (fy / RATIO + b + COARSE_Y - 1) % COARSE_Y;
					iz = (fz / RATIO + c + COARSE_Z - 1) % COARSE_Z;
					acc += pw * longint'(grid[(ix * COARSE_Y + iy) * COARSE_Z + iz]);
				end
			end
		end
		return round_shift(acc, 16);
	endfunction

	function automatic logic signed [31:0] normalize_coef(longint fsum);
		logic [127:0]        num;
		logic [127:0]        q;
		longint unsigned     cm;
		longint unsigned     fm;
		bit                  neg;
		if (fsum == 0) return 0;
		neg = (grid_sum < 0) != (fsum < 0);
		cm = (grid_sum < 0) ? -grid_sum : grid_sum;
		fm = (fsum < 0) ? -fsum : fsum;
		num = 128'(cm) * 128'(vol_ratio);
		q = num / 128'(fm);
		if (!neg && q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
		if (neg && q > 128'h8000_0000) q = 128'h8000_0000;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic upsample_result_t predict_result(logic [1:0] cmd, logic signed [31:0] smp,
			logic [7:0] fx, logic [7:0] fy, logic [7:0] fz);
		upsample_result_t res;
		longint           fsum;
		longint           f;
		longint unsigned  fm;
		longint unsigned  m;
		longint           v;
		bit               neg;
		res.value = 0;
		res.status = ST_OK;
		case (cmd)
			CMD_LOAD: begin
				if (samples_loaded >= NCOARSE) begin
					samples_loaded = 0;
					grid_sum = 0;
				end
				grid[samples_loaded] = smp;
				grid_sum += longint'(smp);
				samples_loaded++;
				normalized = 0;
			end
			CMD_FINISH: begin
				if (samples_loaded < NCOARSE) begin
					res.status = ST_NOT_READY;
				end else begin
					fsum = 0;
					for (int x = 0; x < FINE_X; x++)
						for (int y = 0; y < FINE_Y; y++)
							for (int z = 0; z < FINE_Z; z++) begin
								f = interpolate(x, y, z);
								fine_cache[(x * FINE_Y + y) * FINE_Z + z] = f;
								fsum += f;
							end
					coef = normalize_coef(fsum);
					normalized = 1;
					res.value = coef;
				end
			end
			CMD_READ: begin
				if (!normalized) begin
					res.status = ST_NOT_READY;
				end else if (fx >= FINE_X || fy >= FINE_Y || fz >= FINE_Z) begin
					res.status = ST_RANGE;
				end else begin
					f = fine_cache[(int'(fx) * FINE_Y + int'(fy)) * FINE_Z + int'(fz)];
					fm = (f < 0) ? -f : f;
					if (fm > 64'h1_FFFF_FFFF) fm = 64'h1_FFFF_FFFF;
					neg = (f < 0) != (coef < 0);
					m = fm * ((coef < 0) ? -longint'(coef) : longint'(coef));
					m = (m + 64'h8000) >> 16;
					if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
					v = neg ? -longint'(m) : longint'(m);
					if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
					if (v < -64'sh8000_0000) v = -64'sh8000_0000;
					res.value = v[31:0];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		upsample_result_t want;
		if (!arst_n) begin
			samples_loaded = 0;
			grid_sum = 0;
			coef = 0;
			normalized = 0;
			vol_ratio = 24'h08_0000;
		end else begin
			if (cfg_we) vol_ratio = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(predict_result(in_ch.command, in_ch.sample,
					in_ch.fine_x, in_ch.fine_y, in_ch.fine_z));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result transaction", out_ch.value, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_ch.value !== want.value)
						report_mismatch("value", out_ch.value, want.value);
					if (out_ch.status !== want.status)
						report_mismatch("status", out_ch.status, want.status);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_tricubic_grid_upsampler_top.sv =====
// Testbench top of the tricubic grid upsampler: stimulus, receiver pacing and verdict.
`default_nettype none
module tb_tricubic_grid_upsampler_top import tgu_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1_500_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	tgu_in_if  in_ch();
	tgu_out_if out_ch();

	tricubic_grid_upsampler_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	tgu_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD;
		in_ch.sample = '0;
		in_ch.fine_x = '0;
		in_ch.fine_y = '0;
		in_ch.fine_z = '0;
		out_ch.ready = 1'b0;
	end

	// The long hold-off is counted here so the sender keeps pushing meanwhile.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_tricubic_grid_upsampler_top NOT OK");
			$finish;
		end
	end

	task automatic send(logic [1:0] cmd, logic signed [31:0] smp,
			logic [7:0] fx, logic [7:0] fy, logic [7:0] fz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.sample <= smp;
		in_ch.fine_x <= fx;
		in_ch.fine_y <= fy;
		in_ch.fine_z <= fz;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_ratio(logic [23:0] ratio);
		cfg_we <= 1'b1;
		cfg_wdata <= ratio;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_sample(int kind);
		case (kind)
			0: return 32'sh1_0000 + $signed(32'($urandom_range(65535))) - 32'sh8000;
			1: return ($urandom_range(9) < 2) ? $signed($urandom())
				: $signed(32'($urandom_range(1 << 22))) - 32'sh20_0000;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] pick_coord(int span);
		return ($urandom_range(99) < 85) ? 8'($urandom_range(span - 1))
			: 8'($urandom_range(255));
	endfunction

	// Stray commands that must not disturb a grid being loaded.
	task automatic send_noise();
		case ($urandom_range(2))
			0: send(CMD_FINISH, $urandom(), 8'($urandom()), 8'($urandom()), 8'($urandom()));
			1: send(CMD_READ, $urandom(), pick_coord(FINE_X), pick_coord(FINE_Y),
				pick_coord(FINE_Z));
			default: send(CMD_NOP, $urandom(), 8'($urandom()), 8'($urandom()),
				8'($urandom()));
		endcase
	endtask

	task automatic load_grid(int kind);
		for (int n = 0; n < NCOARSE; n++) begin
			send(CMD_LOAD, pick_sample(kind), 8'($urandom()), 8'($urandom()),
				8'($urandom()));
			if (n == 0) send(CMD_READ, $urandom(), 8'd0, 8'd0, 8'd0);
			if ($urandom_range(99) < 3) send_noise();
		end
		send(CMD_FINISH, $urandom(), 8'($urandom()), 8'($urandom()), 8'($urandom()));
	endtask

	task automatic read_points(int count, bit with_hold);
		send(CMD_READ, 0, 8'd0, 8'd0, 8'd0);
		send(CMD_READ, 0, 8'(FINE_X - 1), 8'(FINE_Y - 1), 8'(FINE_Z - 1));
		send(CMD_READ, 0, 8'(FINE_X), 8'd0, 8'd0);
		send(CMD_READ, 0, 8'd0, 8'(FINE_Y), 8'd0);
		send(CMD_READ, 0, 8'd0, 8'd0, 8'(FINE_Z));
		send(CMD_READ, 0, 8'hFF, 8'hFF, 8'hFF);
		for (int k = 0; k < count; k++) begin
			if (with_hold && k == count / 2) hold_request = 600;
			send(CMD_READ, $urandom(), pick_coord(FINE_X), pick_coord(FINE_Y),
				pick_coord(FINE_Z));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_READ, 0, 8'd0, 8'd0, 8'd0);
		send(CMD_FINISH, 0, 8'd0, 8'd0, 8'd0);
		send(CMD_NOP, 32'shFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
		send(CMD_LOAD, 32'sh7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
		send(CMD_LOAD, 32'sh8000_0000, 8'd0, 8'd0, 8'd0);
		send(CMD_LOAD, 0, 8'd0, 8'd0, 8'd0);
		send(CMD_LOAD, -1, 8'd0, 8'd0, 8'd0);
		send(CMD_FINISH, 0, 8'd0, 8'd0, 8'd0);
		send(CMD_READ, 0, 8'hFF, 8'hFF, 8'hFF);

		// The directed loads above begin the first grid, so it is topped up to a full one.
		for (int n = 4; n < NCOARSE; n++)
			send(CMD_LOAD, pick_sample(0), 8'($urandom()), 8'($urandom()),
				8'($urandom()));
		send(CMD_FINISH, 0, 8'd0, 8'd0, 8'd0);
		send_idle_pct = 58;
		read_points(50, 0);

		drain();
		write_ratio(24'hFF_FFFF);
		send_idle_pct = 0;
		stall_pct = 58;
		load_grid(1);
		send_idle_pct = 35;
		stall_pct = 35;
		read_points(50, 1);

		drain();
		write_ratio(24'h00_0000);
		send_idle_pct = 58;
		stall_pct = 0;
		load_grid(2);
		send_idle_pct = 35;
		stall_pct = 35;
		read_points(20, 0);

		drain();
		if (fail_count == 0)
			$display("tb_tricubic_grid_upsampler_top OK");
		else
			$display("tb_tricubic_grid_upsampler_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
